// ----- hw/rtl/address_range_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Address range allocator assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_ALLOCATOR_DEFINES_SVH
`define ADDRESS_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define ARA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ara_pkg.sv -----
// ----------------------------------------------------------------------------
// Address range allocator package
// Table sizes, page limit, codes and shared types.
// ----------------------------------------------------------------------------
package ara_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 32;
    localparam int PAGE_BYTES = 4096;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W = 20;
    localparam int PAGES_W = 21;
    localparam int ID_W   = 6;
    localparam int SW     = 25;

    localparam longint unsigned RAW_LIMIT = (64'd1 << ADDR_BITS) / PAGE_BYTES;
    localparam longint unsigned FIELD_PAGES = 64'd1048576;
    localparam longint unsigned LIMIT_U = (RAW_LIMIT > FIELD_PAGES) ? FIELD_PAGES : RAW_LIMIT;
    localparam logic signed [SW-1:0] PAGE_LIMIT = SW'(LIMIT_U);

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_BLOCKS);

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_SWITCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_SPACE_BEGIN = 1'b0;
    localparam logic CFG_SPACE_PAGES = 1'b1;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [ID_W-1:0]    owner;
    } row_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        row_t             row;
    } wr_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DISPATCH, S_FIT_RD, S_FIT_CHK,
        S_LIMIT, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR, S_ERASE_RD, S_ERASE_WR,
        S_SWITCH_WR, S_FINISH
    } state_t;

endpackage

// ----- hw/rtl/address_range_allocator.sv -----
// ----------------------------------------------------------------------------
// Address range allocator
// Top-down first-fit page range allocator over an address-sorted row table.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | req_type block_id other_id size_pages guard_pages
//  out     | out_valid / out_stall  | address_page status
//  cfg     | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// One request at a time; every table row visit is a read state then a check or write
// state on the single table read port (id scan, downward gap search, shift for insert
// or erase).
// Reset empties the table at once; rows are never cleared.
// Output register holds a result while stalled; the next transfer is taken meanwhile.
// ----------------------------------------------------------------------------
`include "address_range_allocator_defines.svh"

module address_range_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [5:0]  block_id,
    input  logic [5:0]  other_id,
    input  logic [20:0] size_pages,
    input  logic [20:0] guard_pages,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] address_page,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data
);

    localparam int SW = ara_pkg::SW;
    localparam int CW = ara_pkg::CNT_W;
    localparam int IW = ara_pkg::IDX_W;

    ara_pkg::state_t state_reg, state_next;

    logic [19:0]       begin_reg;
    logic [20:0]       space_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [1:0]        req_reg, req_next;
    logic [5:0]        id_reg, id_next;
    logic [5:0]        other_reg, other_next;
    logic [20:0]       size_reg, size_next;
    logic [20:0]       guard_reg, guard_next;
    logic              hid_reg, hid_next;
    logic [CW-1:0]     hid_idx_reg, hid_idx_next;
    logic              hoth_reg, hoth_next;
    logic [CW-1:0]     hoth_idx_reg, hoth_idx_next;
    ara_pkg::row_t     hrow_reg, hrow_next;
    logic signed [SW-1:0] end_reg, end_next;
    logic signed [SW-1:0] place_reg, place_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [19:0]       res_addr_reg, res_addr_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              out_valid_reg;
    logic [19:0]       out_addr_reg;
    logic [1:0]        out_st_reg;

    ara_pkg::wr_t      wr;
    logic [IW-1:0]     rd_addr;
    ara_pkg::row_t     rd_row;

    logic signed [SW-1:0] begin_s, size_s, guard_s, need_s, end_init;
    logic signed [SW-1:0] rb_s, re_s, gap_s;
    logic fit_ok, first_ok, empty_ok, limit_bad;
    logic in_acc, out_free;

    ara_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    assign begin_s  = $signed({{(SW-20){1'b0}}, begin_reg});
    assign size_s   = $signed({{(SW-21){1'b0}}, size_reg});
    assign guard_s  = $signed({{(SW-21){1'b0}}, guard_reg});
    assign need_s   = size_s + guard_s;
    assign end_init = begin_s + $signed({{(SW-21){1'b0}}, space_reg});
    assign rb_s     = $signed({{(SW-20){1'b0}}, rd_row.base});
    assign re_s     = rb_s + $signed({{(SW-21){1'b0}}, rd_row.pages});
    assign gap_s    = end_reg - re_s;
    assign fit_ok   = gap_s >= need_s;
    assign first_ok = !(rb_s < begin_s + need_s);
    assign empty_ok = !(space_reg < size_reg);
    assign limit_bad = (place_reg >= ara_pkg::PAGE_LIMIT)
                    || (place_reg + size_s > ara_pkg::PAGE_LIMIT);

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ara_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign address_page = out_addr_reg;
    assign status = out_st_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ara_pkg::S_IDLE:
                if (in_acc)
                begin
                    state_next = (count_reg == '0) ? ara_pkg::S_DISPATCH : ara_pkg::S_SCAN_RD;
                end
            ara_pkg::S_SCAN_RD:
                state_next = ara_pkg::S_SCAN_CHK;
            ara_pkg::S_SCAN_CHK:
                state_next = (idx_reg + 1'b1 == count_reg) ? ara_pkg::S_DISPATCH
                                                           : ara_pkg::S_SCAN_RD;
            ara_pkg::S_DISPATCH:
                case (req_reg)
                    ara_pkg::REQ_ALLOC:
                        if (count_reg == ara_pkg::COUNT_FULL || hid_reg)
                            state_next = ara_pkg::S_FINISH;
                        else if (count_reg == '0)
                            state_next = empty_ok ? ara_pkg::S_LIMIT : ara_pkg::S_FINISH;
                        else
                            state_next = ara_pkg::S_FIT_RD;
                    ara_pkg::REQ_FREE:
                        if (hid_reg && (hid_idx_reg + 1'b1 < count_reg))
                            state_next = ara_pkg::S_ERASE_RD;
                        else
                            state_next = ara_pkg::S_FINISH;
                    ara_pkg::REQ_SWITCH:
                        if (!hoth_reg || (hid_reg && hid_idx_reg != hoth_idx_reg))
                            state_next = ara_pkg::S_FINISH;
                        else
                            state_next = ara_pkg::S_SWITCH_WR;
                    default:
                        state_next = ara_pkg::S_FINISH;
                endcase
            ara_pkg::S_FIT_RD:
                state_next = ara_pkg::S_FIT_CHK;
            ara_pkg::S_FIT_CHK:
                if (fit_ok)
                    state_next = ara_pkg::S_LIMIT;
                else if (idx_reg == '0)
                    state_next = first_ok ? ara_pkg::S_LIMIT : ara_pkg::S_FINISH;
                else
                    state_next = ara_pkg::S_FIT_RD;
            ara_pkg::S_LIMIT:
                if (limit_bad)
                    state_next = ara_pkg::S_FINISH;
                else if (count_reg > pos_reg)
                    state_next = ara_pkg::S_SHIFT_RD;
                else
                    state_next = ara_pkg::S_INS_WR;
            ara_pkg::S_SHIFT_RD:
                state_next = ara_pkg::S_SHIFT_WR;
            ara_pkg::S_SHIFT_WR:
                state_next = (idx_reg - 1'b1 > pos_reg) ? ara_pkg::S_SHIFT_RD
                                                        : ara_pkg::S_INS_WR;
            ara_pkg::S_INS_WR:
                state_next = ara_pkg::S_FINISH;
            ara_pkg::S_ERASE_RD:
                state_next = ara_pkg::S_ERASE_WR;
            ara_pkg::S_ERASE_WR:
                state_next = (idx_reg + 2'd2 < count_reg) ? ara_pkg::S_ERASE_RD
                                                          : ara_pkg::S_FINISH;
            ara_pkg::S_SWITCH_WR:
                state_next = ara_pkg::S_FINISH;
            ara_pkg::S_FINISH:
                if (out_free)
                    state_next = ara_pkg::S_IDLE;
            default:
                state_next = ara_pkg::S_IDLE;
        endcase
    end

    // datapath and table ports
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        other_next    = other_reg;
        size_next     = size_reg;
        guard_next    = guard_reg;
        hid_next      = hid_reg;
        hid_idx_next  = hid_idx_reg;
        hoth_next     = hoth_reg;
        hoth_idx_next = hoth_idx_reg;
        hrow_next     = hrow_reg;
        end_next      = end_reg;
        place_next    = place_reg;
        pos_next      = pos_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        rd_addr       = idx_reg[IW-1:0];
        wr            = '0;
        case (state_reg)
            ara_pkg::S_IDLE:
                if (in_acc)
                begin
                    req_next   = req_type;
                    id_next    = block_id;
                    other_next = other_id;
                    size_next  = size_pages;
                    guard_next = guard_pages;
                    idx_next   = '0;
                    hid_next   = 1'b0;
                    hoth_next  = 1'b0;
                    res_addr_next = '0;
                    res_st_next   = ara_pkg::ST_OK;
                end
            ara_pkg::S_SCAN_CHK:
            begin
                if (!hid_reg && rd_row.owner == id_reg)
                begin
                    hid_next     = 1'b1;
                    hid_idx_next = idx_reg;
                end
                if (!hoth_reg && rd_row.owner == other_reg)
                begin
                    hoth_next     = 1'b1;
                    hoth_idx_next = idx_reg;
                    hrow_next     = rd_row;
                end
                idx_next = idx_reg + 1'b1;
            end
            ara_pkg::S_DISPATCH:
                case (req_reg)
                    ara_pkg::REQ_ALLOC:
                    begin
                        end_next   = end_init;
                        idx_next   = count_reg - 1'b1;
                        place_next = begin_s;
                        pos_next   = '0;
                        if (count_reg == ara_pkg::COUNT_FULL)
                            res_st_next = ara_pkg::ST_FULL;
                        else if (hid_reg)
                            res_st_next = ara_pkg::ST_UNKNOWN;
                        else if (count_reg == '0 && !empty_ok)
                            res_st_next = ara_pkg::ST_NOSPACE;
                    end
                    ara_pkg::REQ_FREE:
                    begin
                        idx_next = hid_idx_reg;
                        if (!hid_reg)
                            res_st_next = ara_pkg::ST_UNKNOWN;
                        else if (!(hid_idx_reg + 1'b1 < count_reg))
                            count_next = count_reg - 1'b1;
                    end
                    ara_pkg::REQ_SWITCH:
                        if (!hoth_reg || (hid_reg && hid_idx_reg != hoth_idx_reg))
                            res_st_next = ara_pkg::ST_UNKNOWN;
                        else
                            res_addr_next = hrow_reg.base;
                    default:
                        res_st_next = ara_pkg::ST_OK;
                endcase
            ara_pkg::S_FIT_CHK:
                if (fit_ok)
                begin
                    place_next = re_s + guard_s;
                    pos_next   = idx_reg + 1'b1;
                end
                else
                begin
                    end_next = rb_s - guard_s;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == '0 && !first_ok)
                        res_st_next = ara_pkg::ST_NOSPACE;
                end
            ara_pkg::S_LIMIT:
            begin
                idx_next = count_reg;
                if (limit_bad)
                    res_st_next = ara_pkg::ST_NOSPACE;
            end
            ara_pkg::S_SHIFT_RD:
                rd_addr = IW'(idx_reg - 1'b1);
            ara_pkg::S_SHIFT_WR:
            begin
                wr.en    = 1'b1;
                wr.addr  = idx_reg[IW-1:0];
                wr.row   = rd_row;
                idx_next = idx_reg - 1'b1;
            end
            ara_pkg::S_INS_WR:
            begin
                wr.en           = 1'b1;
                wr.addr         = pos_reg[IW-1:0];
                wr.row.base     = place_reg[19:0];
                wr.row.pages    = size_reg;
                wr.row.owner    = id_reg;
                count_next      = count_reg + 1'b1;
                res_addr_next   = place_reg[19:0];
            end
            ara_pkg::S_ERASE_RD:
                rd_addr = IW'(idx_reg + 1'b1);
            ara_pkg::S_ERASE_WR:
            begin
                wr.en    = 1'b1;
                wr.addr  = idx_reg[IW-1:0];
                wr.row   = rd_row;
                idx_next = idx_reg + 1'b1;
                if (!(idx_reg + 2'd2 < count_reg))
                    count_next = count_reg - 1'b1;
            end
            ara_pkg::S_SWITCH_WR:
            begin
                wr.en        = 1'b1;
                wr.addr      = hoth_idx_reg[IW-1:0];
                wr.row       = hrow_reg;
                wr.row.owner = id_reg;
            end
            default:
                rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ara_pkg::S_IDLE;
            count_reg     <= '0;
            begin_reg     <= '0;
            space_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ara_pkg::CFG_SPACE_BEGIN)
                    begin_reg <= cfg_data[19:0];
                else if (cfg_index == ara_pkg::CFG_SPACE_PAGES)
                    space_reg <= cfg_data;
            end
            if (state_reg == ara_pkg::S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        id_reg       <= id_next;
        other_reg    <= other_next;
        size_reg     <= size_next;
        guard_reg    <= guard_next;
        hid_reg      <= hid_next;
        hid_idx_reg  <= hid_idx_next;
        hoth_reg     <= hoth_next;
        hoth_idx_reg <= hoth_idx_next;
        hrow_reg     <= hrow_next;
        end_reg      <= end_next;
        place_reg    <= place_next;
        pos_reg      <= pos_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        if (state_reg == ara_pkg::S_FINISH && out_free)
        begin
            out_addr_reg <= (res_st_reg == ara_pkg::ST_OK) ? res_addr_reg : '0;
            out_st_reg   <= res_st_reg;
        end
    end

    `ARA_ASSERT_NOW(a_count_max, 1'b1, count_reg <= ara_pkg::COUNT_FULL, "row count overflow")
    `ARA_ASSERT_NOW(a_wr_in_range, wr.en, {1'b0, wr.addr} <= count_reg, "write beyond table")
    `ARA_ASSERT_NEXT(a_busy_after_take, in_acc, state_reg != ara_pkg::S_IDLE, "idle after transfer")
    `ARA_ASSERT_NOW(a_fail_zero_addr, out_valid_reg && out_st_reg != ara_pkg::ST_OK,
        out_addr_reg == '0, "address on failed request")

endmodule

// ----- hw/rtl/ara_table.sv -----
// ----------------------------------------------------------------------------
// Address range allocator row table
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ara_table (
    input  logic                       clk,
    input  ara_pkg::wr_t               wr,
    input  logic [ara_pkg::IDX_W-1:0]  rd_addr,
    output ara_pkg::row_t              rd_row
);

    ara_pkg::row_t mem [ara_pkg::MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.row;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row <= mem[rd_addr];
    end

endmodule
